>>> rtl/spq_pkg.sv
// shared types and codes for the sorted priority queue
`default_nettype none

package spq_pkg;

    // fixed field widths
    localparam int PRIORITY_BITS = 16;
    localparam int PAYLOAD_BITS  = 32;
    localparam int CAP_BITS      = 7;

    // action codes
    localparam logic [1:0] ACT_ENQ  = 2'd0;
    localparam logic [1:0] ACT_DEQ  = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                      action;
        logic signed [PRIORITY_BITS-1:0] priority_req;
        logic [PAYLOAD_BITS-1:0]         payload;
    } req_t;

    typedef struct packed {
        logic [1:0]                      status;
        logic signed [PRIORITY_BITS-1:0] out_priority;
        logic [PAYLOAD_BITS-1:0]         out_payload;
        logic [CAP_BITS-1:0]             occupancy;
    } rsp_t;

    typedef struct packed {
        logic signed [PRIORITY_BITS-1:0] prio;
        logic [PAYLOAD_BITS-1:0]         payload;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/spq_cell.sv
// one cell of the sorted chain: holds a single entry
`default_nettype none

module spq_cell (
    input  wire logic                clk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire logic                occupied,
    input  wire logic                left_greater,
    input  wire spq_pkg::entry_t     left_entry,
    input  wire spq_pkg::entry_t     right_entry,
    output logic                     greater,
    output spq_pkg::entry_t          entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // stored entry ranks after the new one
    assign greater = occupied &&
                     ($signed(entry_reg.prio) > $signed(ctrl.new_entry.prio));
    assign entry   = entry_reg;

    // shift right on insert, shift left on removal
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (left_greater)
                entry_next = left_entry;
            else if (greater || !occupied)
                entry_next = ctrl.new_entry;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// sorted priority queue: top level with count, capacity and result register
// the result of an accepted request is captured in the result register
// throughput: one request per cycle while not held off; every cell of the chain updates together
// a request is held off only while the result register is full and stalled
// reset clears the entry count, sets capacity to 64 and drops the result valid
// entry contents are not reset; only cells below the count ever reach the result
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire spq_pkg::req_t              req,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output spq_pkg::rsp_t                   rsp,
    input  wire logic                       cfg_we,
    input  wire logic [spq_pkg::CAP_BITS-1:0] cfg_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > spq_pkg::CAP_BITS) ? CW : spq_pkg::CAP_BITS;

    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [spq_pkg::CAP_BITS-1:0]  capacity_reg;
    logic                          out_valid_reg;
    spq_pkg::rsp_t                 out_reg;
    spq_pkg::rsp_t                 out_next;

    logic                          accept;
    logic                          is_full;
    logic                          is_empty;
    logic                          enq_ok;
    logic                          deq_ok;
    spq_pkg::cell_ctrl_t           ctrl;

    logic [DEPTH-1:0]              occ;
    logic [DEPTH-1:0]              greater;
    spq_pkg::entry_t               entries [DEPTH];

    // handshake
    assign req_stall = out_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // limit checks
    assign is_full  = (CMPW'(count_reg) >= CMPW'(capacity_reg)) ||
                      (count_reg >= CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign enq_ok   = accept && (req.action == spq_pkg::ACT_ENQ) && !is_full;
    assign deq_ok   = accept && (req.action == spq_pkg::ACT_DEQ) && !is_empty;

    // broadcast to the chain
    always_comb
    begin
        ctrl.enq               = enq_ok;
        ctrl.deq               = deq_ok;
        ctrl.new_entry.prio    = req.priority_req;
        ctrl.new_entry.payload = req.payload;
    end

    // chain of cells
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign occ[i] = (count_reg > CW'(i));

            if (i == 0)
            begin : g_first
                spq_cell u_cell (
                    .clk          (clk),
                    .ctrl         (ctrl),
                    .occupied     (occ[i]),
                    .left_greater (1'b0),
                    .left_entry   (entries[i]),
                    .right_entry  (entries[i+1]),
                    .greater      (greater[i]),
                    .entry        (entries[i])
                );
            end
            else if (i == DEPTH - 1)
            begin : g_last
                spq_cell u_cell (
                    .clk          (clk),
                    .ctrl         (ctrl),
                    .occupied     (occ[i]),
                    .left_greater (greater[i-1]),
                    .left_entry   (entries[i-1]),
                    .right_entry  (entries[i]),
                    .greater      (greater[i]),
                    .entry        (entries[i])
                );
            end
            else
            begin : g_mid
                spq_cell u_cell (
                    .clk          (clk),
                    .ctrl         (ctrl),
                    .occupied     (occ[i]),
                    .left_greater (greater[i-1]),
                    .left_entry   (entries[i-1]),
                    .right_entry  (entries[i+1]),
                    .greater      (greater[i]),
                    .entry        (entries[i])
                );
            end
        end
    endgenerate

    // next count
    always_comb
    begin
        count_next = count_reg;
        if (enq_ok)
            count_next = count_reg + 1'b1;
        else if (deq_ok)
            count_next = count_reg - 1'b1;
    end

    // result of the accepted request
    always_comb
    begin
        out_next.status       = spq_pkg::ST_OK;
        out_next.out_priority = '0;
        out_next.out_payload  = '0;
        out_next.occupancy    = spq_pkg::CAP_BITS'(count_next);
        unique case (req.action) inside
            spq_pkg::ACT_ENQ:
            begin
                if (is_full)
                    out_next.status = spq_pkg::ST_FULL;
            end
            spq_pkg::ACT_DEQ, spq_pkg::ACT_PEEK:
            begin
                if (is_empty)
                    out_next.status = spq_pkg::ST_EMPTY;
                else
                begin
                    out_next.out_priority = entries[0].prio;
                    out_next.out_payload  = entries[0].payload;
                end
            end
            default:
            begin
                out_next.status = spq_pkg::ST_OK;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            capacity_reg  <= spq_pkg::CAP_BITS'(64);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
                capacity_reg <= cfg_data;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        enq_ok |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the count");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        deq_ok |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("removal did not shrink the count");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != spq_pkg::ST_OK)) |->
        ((out_reg.out_priority == '0) && (out_reg.out_payload == '0)))
        else $error("refused request carries data");

endmodule

`default_nettype wire

>>> tb/tb_sorted_priority_queue.sv
// self-checking testbench for the sorted priority queue: directed table, then random phases
`timescale 1ns / 100ps

module tb_sorted_priority_queue;

    localparam int DEPTH       = 64;
    localparam int NUM_STEPS   = 27;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 175;

    // unused action code, the block answers it without touching the queue
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic signed [spq_pkg::PRIORITY_BITS-1:0] P_MIN = 16'sh8000;
    localparam logic signed [spq_pkg::PRIORITY_BITS-1:0] P_MAX = 16'sh7fff;

    // one row of the directed table: either a capacity write or a request
    typedef struct packed {
        logic                         set_cap;
        logic [spq_pkg::CAP_BITS-1:0] cap;
        spq_pkg::req_t                item;
        logic                         known;
        spq_pkg::rsp_t                want;
    } step_t;

    localparam step_t DIRECTED [NUM_STEPS] = '{
        // empty queue after reset
        '{1'b0, 7'd0, '{spq_pkg::ACT_PEEK, 16'sd0, 32'd0}, 1'b1,
          '{spq_pkg::ST_EMPTY, 16'sd0, 32'd0, 7'd0}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_DEQ, 16'sd0, 32'd0}, 1'b1,
          '{spq_pkg::ST_EMPTY, 16'sd0, 32'd0, 7'd0}},
        '{1'b0, 7'd0, '{ACT_NONE, P_MAX, 32'hffffffff}, 1'b1,
          '{spq_pkg::ST_OK, 16'sd0, 32'd0, 7'd0}},
        // extremes, ties and alternating bit patterns
        '{1'b0, 7'd0, '{spq_pkg::ACT_ENQ, P_MAX, 32'hffffffff}, 1'b1,
          '{spq_pkg::ST_OK, 16'sd0, 32'd0, 7'd1}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_ENQ, P_MIN, 32'd0}, 1'b1,
          '{spq_pkg::ST_OK, 16'sd0, 32'd0, 7'd2}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_PEEK, 16'sd0, 32'd0}, 1'b1,
          '{spq_pkg::ST_OK, P_MIN, 32'd0, 7'd2}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_ENQ, 16'sd0, 32'd1}, 1'b1,
          '{spq_pkg::ST_OK, 16'sd0, 32'd0, 7'd3}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_ENQ, 16'sd0, 32'd2}, 1'b1,
          '{spq_pkg::ST_OK, 16'sd0, 32'd0, 7'd4}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_ENQ, 16'sh5555, 32'haaaaaaaa}, 1'b0, '0},
        '{1'b0, 7'd0, '{spq_pkg::ACT_ENQ, 16'shaaaa, 32'h55555555}, 1'b0, '0},
        '{1'b0, 7'd0, '{ACT_NONE, 16'sh1234, 32'h89abcdef}, 1'b1,
          '{spq_pkg::ST_OK, 16'sd0, 32'd0, 7'd6}},
        // drain in order, equal priorities in arrival order
        '{1'b0, 7'd0, '{spq_pkg::ACT_DEQ, 16'sd0, 32'd0}, 1'b1,
          '{spq_pkg::ST_OK, P_MIN, 32'd0, 7'd5}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_DEQ, 16'sd0, 32'd0}, 1'b0, '0},
        '{1'b0, 7'd0, '{spq_pkg::ACT_DEQ, 16'sd0, 32'd0}, 1'b1,
          '{spq_pkg::ST_OK, 16'sd0, 32'd1, 7'd3}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_DEQ, 16'sd0, 32'd0}, 1'b1,
          '{spq_pkg::ST_OK, 16'sd0, 32'd2, 7'd2}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_DEQ, 16'sd0, 32'd0}, 1'b0, '0},
        '{1'b0, 7'd0, '{spq_pkg::ACT_DEQ, 16'sd0, 32'd0}, 1'b1,
          '{spq_pkg::ST_OK, P_MAX, 32'hffffffff, 7'd0}},
        // capacity of one
        '{1'b1, 7'd1, '{ACT_NONE, 16'sd0, 32'd0}, 1'b0, '0},
        '{1'b0, 7'd0, '{spq_pkg::ACT_ENQ, -16'sd1, 32'hdeadbeef}, 1'b1,
          '{spq_pkg::ST_OK, 16'sd0, 32'd0, 7'd1}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_ENQ, 16'sd5, 32'd7}, 1'b1,
          '{spq_pkg::ST_FULL, 16'sd0, 32'd0, 7'd1}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_PEEK, 16'sd0, 32'd0}, 1'b1,
          '{spq_pkg::ST_OK, -16'sd1, 32'hdeadbeef, 7'd1}},
        // capacity zero, lowered below the count
        '{1'b1, 7'd0, '{ACT_NONE, 16'sd0, 32'd0}, 1'b0, '0},
        '{1'b0, 7'd0, '{spq_pkg::ACT_ENQ, 16'sd3, 32'd3}, 1'b1,
          '{spq_pkg::ST_FULL, 16'sd0, 32'd0, 7'd1}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_DEQ, 16'sd0, 32'd0}, 1'b1,
          '{spq_pkg::ST_OK, -16'sd1, 32'hdeadbeef, 7'd0}},
        '{1'b0, 7'd0, '{spq_pkg::ACT_ENQ, 16'sd3, 32'd3}, 1'b1,
          '{spq_pkg::ST_FULL, 16'sd0, 32'd0, 7'd0}},
        // capacity above the depth
        '{1'b1, 7'd127, '{ACT_NONE, 16'sd0, 32'd0}, 1'b0, '0},
        '{1'b0, 7'd0, '{spq_pkg::ACT_ENQ, 16'sd1, 32'h80000000}, 1'b0, '0}
    };

    localparam logic [spq_pkg::CAP_BITS-1:0] PHASE_CAP [NUM_PHASES] =
        '{7'd127, 7'd64, 7'd0, 7'd1, 7'd2, 7'd64, 7'd5, 7'd100, 7'd33, 7'd64};
    localparam int PHASE_ENQ_PCT [NUM_PHASES] = '{85, 60, 25, 50, 50, 80, 30, 70, 55, 40};

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         req_valid = 1'b0;
    logic                         req_stall;
    spq_pkg::req_t                req       = '0;
    logic                         rsp_valid;
    logic                         rsp_stall = 1'b0;
    spq_pkg::rsp_t                rsp;
    logic                         cfg_we    = 1'b0;
    logic [spq_pkg::CAP_BITS-1:0] cfg_data  = '0;

    // queue contents as the block should hold them, head first
    spq_pkg::entry_t              sorted_entries [$];
    logic [spq_pkg::CAP_BITS-1:0] capacity_reg = 7'd64;
    spq_pkg::rsp_t                pending_results [$];
    spq_pkg::rsp_t                oldest_result;
    int unsigned                  mismatches = 0;
    int unsigned                  stall_run  = 0;
    bit                           calm       = 1'b0;

    sorted_priority_queue #(.DEPTH(DEPTH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // queue behaviour for one request, updates the held entries
    function automatic spq_pkg::rsp_t serve_request(input spq_pkg::req_t item);
        spq_pkg::rsp_t res;
        int unsigned   limit;
        int unsigned   pos;
        res   = '0;
        limit = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
        case (item.action) inside
            spq_pkg::ACT_ENQ:
            begin
                if (sorted_entries.size() >= limit)
                    res.status = spq_pkg::ST_FULL;
                else
                begin
                    // insert behind every entry of equal or lower priority
                    pos = 0;
                    while (pos < sorted_entries.size() &&
                           $signed(sorted_entries[pos].prio) <= $signed(item.priority_req))
                        pos++;
                    sorted_entries.insert(pos, '{item.priority_req, item.payload});
                end
            end
            spq_pkg::ACT_DEQ, spq_pkg::ACT_PEEK:
            begin
                if (sorted_entries.size() == 0)
                    res.status = spq_pkg::ST_EMPTY;
                else
                begin
                    res.out_priority = sorted_entries[0].prio;
                    res.out_payload  = sorted_entries[0].payload;
                    if (item.action == spq_pkg::ACT_DEQ)
                        void'(sorted_entries.pop_front());
                end
            end
            default: ;
        endcase
        res.occupancy = spq_pkg::CAP_BITS'(sorted_entries.size());
        return res;
    endfunction

    // small ranges for ties, full range, and the extremes
    function automatic logic signed [spq_pkg::PRIORITY_BITS-1:0] random_priority();
        case ($urandom_range(0, 9)) inside
            0:
                case ($urandom_range(0, 3))
                    0:       return P_MIN;
                    1:       return P_MAX;
                    2:       return 16'sd0;
                    default: return -16'sd1;
                endcase
            [1:4]:   return spq_pkg::PRIORITY_BITS'($urandom());
            default: return spq_pkg::PRIORITY_BITS'($urandom_range(0, 15)) - 16'sd8;
        endcase
    endfunction

    function automatic spq_pkg::req_t random_request(input int enq_pct);
        spq_pkg::req_t item;
        int            pick;
        pick              = $urandom_range(0, 99);
        item.priority_req = random_priority();
        item.payload      = $urandom();
        if (pick < 3)
            item.action = ACT_NONE;
        else if (pick < 3 + enq_pct)
            item.action = spq_pkg::ACT_ENQ;
        else if ($urandom_range(0, 3) == 0)
            item.action = spq_pkg::ACT_PEEK;
        else
            item.action = spq_pkg::ACT_DEQ;
        return item;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    endtask

    // present one request and hold it until accepted
    task automatic send_request(input spq_pkg::req_t item, input logic known,
                                input spq_pkg::rsp_t want);
        int            gap;
        spq_pkg::rsp_t predicted;
        gap = idle_cycles();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        predicted = serve_request(item);
        pending_results.push_back(known ? want : predicted);
    endtask

    // stop sending and wait until every result has come back
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [spq_pkg::CAP_BITS-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        capacity_reg  = value;
    endtask

    // receiver back-pressure in random runs
    always @(posedge clk)
    begin
        if (stall_run != 0)
            stall_run <= stall_run - 1;
        else
        begin
            rsp_stall <= !calm && ($urandom_range(0, 2) == 0);
            stall_run <= idle_cycles();
        end
    end

    // result checking against the oldest expectation
    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 64'(rsp), 64'(0));
            else
            begin
                oldest_result = pending_results.pop_front();
                if (rsp.status !== oldest_result.status)
                    report_mismatch("status", 64'(rsp.status),
                                    64'(oldest_result.status));
                if (rsp.out_priority !== oldest_result.out_priority)
                    report_mismatch("out_priority", 64'(rsp.out_priority),
                                    64'(oldest_result.out_priority));
                if (rsp.out_payload !== oldest_result.out_payload)
                    report_mismatch("out_payload", 64'(rsp.out_payload),
                                    64'(oldest_result.out_payload));
                if (rsp.occupancy !== oldest_result.occupancy)
                    report_mismatch("occupancy", 64'(rsp.occupancy),
                                    64'(oldest_result.occupancy));
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int p;
        int i;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < NUM_STEPS; i++)
        begin
            if (DIRECTED[i].set_cap)
            begin
                settle();
                write_capacity(DIRECTED[i].cap);
            end
            else
                send_request(DIRECTED[i].item, DIRECTED[i].known, DIRECTED[i].want);
        end

        // random phases, each under its own capacity
        for (p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            write_capacity(PHASE_CAP[p]);
            calm = (p == 3) || (p == 8);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender holds off until the queue has answered everything
                if ((p == 1 && i == 90) || $urandom_range(0, 199) == 0)
                    settle();
                send_request(random_request(PHASE_ENQ_PCT[p]), 1'b0, '0);
            end
        end
        calm = 1'b0;

        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
